@@ hw/rtl/wfwr_pkg.sv @@
// Shared types, constants, sine table and saturation helper for the wheel frame wrench rotator.
package wfwr_pkg;

	// Sine table geometry.
	localparam int SINE_TABLE_BITS = 10;
	localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
	localparam int QSIZE           = 1 << QTR_BITS;
	localparam int QADDR_W         = QTR_BITS + 1;

	// Datapath widths.
	localparam int WORD_W = 32;
	localparam int WREN_W = WORD_W + 1;
	localparam int MULB_W = 17;
	localparam int PROD_W = WREN_W + MULB_W;
	localparam int FRAC_SHIFT = 15;
	localparam int SHIFT_W = PROD_W - FRAC_SHIFT;
	localparam int FIN_W   = SHIFT_W + 1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_BIAS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_FORCE_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_FORCE_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_FORCE_Z  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_TORQUE_X = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_TORQUE_Y = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_TORQUE_Z = 3'd7;

	// Accumulator operations.
	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;
	localparam logic [1:0] ACC_SUB  = 2'd3;

	typedef struct packed {
		logic [1:0] acc_op;
		logic       bias_en;
	} mac_ctrl_t;

	typedef logic [14:0] qsine_tab_t [QSIZE+1];

	// First-quadrant sine in Q1.15 from a ninth-order odd polynomial, Horner form in Q30.
	function automatic logic [14:0] quarter_sine(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] p;
		x  = 64'(k) << (30 - QTR_BITS);
		x2 = (x * x) >> 30;
		t  = 64'd172271;
		t  = 64'd5026995    - ((x2 * t) >> 30);
		t  = 64'd85569306   - ((x2 * t) >> 30);
		t  = 64'd693598668  - ((x2 * t) >> 30);
		t  = 64'd1686629713 - ((x2 * t) >> 30);
		p  = (((x * t) >> 30) + 64'd16384) >> 15;
		if (p > 64'd32767) begin
			p = 64'd32767;
		end
		return p[14:0];
	endfunction

	function automatic qsine_tab_t build_qsine();
		qsine_tab_t tab;
		for (int k = 0; k <= QSIZE; k++) begin
			tab[k] = quarter_sine(k);
		end
		return tab;
	endfunction

	localparam qsine_tab_t QSINE_TAB = build_qsine();

	// Clamp a signed value to the signed 32-bit range.
	function automatic logic [WORD_W-1:0] sat32(input logic [FIN_W-1:0] v);
		logic [WORD_W-1:0] r;
		if (!v[FIN_W-1] && (v[FIN_W-2:WORD_W-1] != '0)) begin
			r = {1'b0, {(WORD_W-1){1'b1}}};
		end else if (v[FIN_W-1] && (v[FIN_W-2:WORD_W-1] != '1)) begin
			r = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/wfwr_sine.sv @@
// Registered table sine and cosine of the wheel angle in Q1.15.
module wfwr_sine (
	input  logic                             clk,
	input  logic [wfwr_pkg::WORD_W-1:0]      angle,
	output logic signed [15:0]               sin_val,
	output logic signed [15:0]               cos_val
);

	logic [wfwr_pkg::SINE_TABLE_BITS-1:0] idx;
	logic [1:0]                           quad_s;
	logic [1:0]                           quad_c;
	logic [wfwr_pkg::QTR_BITS-1:0]        k;
	logic [wfwr_pkg::QADDR_W-1:0]         addr_s;
	logic [wfwr_pkg::QADDR_W-1:0]         addr_c;
	logic [14:0]                          mag_s;
	logic [14:0]                          mag_c;
	logic [15:0]                          val_s;
	logic [15:0]                          val_c;

	always_comb begin
		idx    = angle[wfwr_pkg::WORD_W-1 -: wfwr_pkg::SINE_TABLE_BITS];
		quad_s = idx[wfwr_pkg::SINE_TABLE_BITS-1 -: 2];
		quad_c = quad_s + 2'd1;
		k      = idx[wfwr_pkg::QTR_BITS-1:0];
		// Odd quadrants run the quarter table backward.
		addr_s = quad_s[0] ? (wfwr_pkg::QADDR_W'(wfwr_pkg::QSIZE) - {1'b0, k}) : {1'b0, k};
		addr_c = quad_c[0] ? (wfwr_pkg::QADDR_W'(wfwr_pkg::QSIZE) - {1'b0, k}) : {1'b0, k};
		mag_s  = wfwr_pkg::QSINE_TAB[addr_s];
		mag_c  = wfwr_pkg::QSINE_TAB[addr_c];
		val_s  = quad_s[1] ? (16'd0 - {1'b0, mag_s}) : {1'b0, mag_s};
		val_c  = quad_c[1] ? (16'd0 - {1'b0, mag_c}) : {1'b0, mag_c};
	end

	always_ff @(posedge clk) begin
		sin_val <= $signed(val_s);
		cos_val <= $signed(val_c);
	end

endmodule

@@ hw/rtl/wfwr_mac.sv @@
// Shared signed multiplier with product register, accumulator and shift-saturate finish.
module wfwr_mac (
	input  logic                                clk,
	input  wfwr_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [wfwr_pkg::WREN_W-1:0]  op_a,
	input  logic signed [wfwr_pkg::MULB_W-1:0]  op_b,
	input  logic [wfwr_pkg::WORD_W-1:0]         vbias,
	output logic [wfwr_pkg::WORD_W-1:0]         prod_low,
	output logic [wfwr_pkg::WORD_W-1:0]         fin
);

	logic signed [wfwr_pkg::PROD_W-1:0] prod_s1;
	logic signed [wfwr_pkg::PROD_W-1:0] acc_q;
	logic signed [wfwr_pkg::SHIFT_W-1:0] shifted;
	logic signed [wfwr_pkg::FIN_W-1:0]   bias_ext;
	logic signed [wfwr_pkg::FIN_W-1:0]   diff;

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk) begin
		case (ctrl.acc_op)
			wfwr_pkg::ACC_LOAD: acc_q <= prod_s1;
			wfwr_pkg::ACC_ADD:  acc_q <= acc_q + prod_s1;
			wfwr_pkg::ACC_SUB:  acc_q <= acc_q - prod_s1;
			default:            acc_q <= acc_q;
		endcase
	end

	// The arithmetic right shift is a floor, as the rotation needs.
	always_comb begin
		shifted  = acc_q[wfwr_pkg::PROD_W-1:wfwr_pkg::FRAC_SHIFT];
		bias_ext = ctrl.bias_en ?
			$signed({{(wfwr_pkg::FIN_W-wfwr_pkg::WORD_W){vbias[wfwr_pkg::WORD_W-1]}}, vbias}) :
			'0;
		diff     = $signed({shifted[wfwr_pkg::SHIFT_W-1], shifted}) - bias_ext;
		fin      = wfwr_pkg::sat32(diff);
		prod_low = prod_s1[wfwr_pkg::WORD_W-1:0];
	end

endmodule

@@ hw/rtl/wheel_frame_wrench_rotator.sv @@
// Top level: wheel angle update and sequenced rotation of the offset-corrected wrench.
//
//  port group | dir | word contents (lowest bits first)
//  s_axis     | in  | raw_force_x/y/z, raw_torque_x/y/z, spin_rate, elapsed_us (240 bits)
//  m_axis     | out | out_force_x/y/z, out_torque_x/y/z, wheel_phase (224 bits)
//  cfg        | in  | write enable, 3-bit register index, 32-bit data
//
// A word passes these steps on its way to the output register, and no new word is taken
// before the sequencer is idle again: angle step product, angle update, table lookup, eight
// products through the single shared 33 x 17 multiplier, last sum, hand-over, then idle.
// s_axis_tready is high only while the sequencer is idle; a finished result waits
// in the output register, so the next word can be taken while m_axis is stalled, and the
// following result holds the sequencer until that register is free again.
// Reset clears the control state, the configuration registers and the wheel angle.
module wheel_frame_wrench_rotator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// raw_force_x, raw_force_y, raw_force_z, raw_torque_x, raw_torque_y,
	// raw_torque_z, spin_rate, elapsed_us
	input  logic [239:0]                        s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_force_x, out_force_y, out_force_z, out_torque_x, out_torque_y,
	// out_torque_z, wheel_phase
	output logic [223:0]                        m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [wfwr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wfwr_pkg::WORD_W-1:0]         cfg_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RATE  = 4'd1;
	localparam logic [3:0] ST_ANGLE = 4'd2;
	localparam logic [3:0] ST_TRIG  = 4'd3;
	localparam logic [3:0] ST_FXS   = 4'd4;
	localparam logic [3:0] ST_FYC   = 4'd5;
	localparam logic [3:0] ST_FXC   = 4'd6;
	localparam logic [3:0] ST_FYS   = 4'd7;
	localparam logic [3:0] ST_TXS   = 4'd8;
	localparam logic [3:0] ST_TYC   = 4'd9;
	localparam logic [3:0] ST_TXC   = 4'd10;
	localparam logic [3:0] ST_TYS   = 4'd11;
	localparam logic [3:0] ST_LAST  = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	localparam int W  = wfwr_pkg::WORD_W;
	localparam int WW = wfwr_pkg::WREN_W;

	logic [3:0]          state_q;
	logic [3:0]          state_nxt;
	logic [W-1:0]        angle_q;
	logic [W-1:0]        vbias_q;
	logic [W-1:0]        bias_q [6];
	logic signed [WW-1:0] w_q [6];
	logic [W-1:0]        rate_q;
	logic [15:0]         dt_q;
	logic [W-1:0]        res_fx_q;
	logic [W-1:0]        res_fz_q;
	logic [W-1:0]        res_tx_q;
	logic                out_valid_q;
	logic [223:0]        out_data_q;

	logic                in_accept;
	logic                out_free;
	logic signed [15:0]  sin_val;
	logic signed [15:0]  cos_val;
	wfwr_pkg::mac_ctrl_t mac_ctrl;
	logic signed [WW-1:0] op_a;
	logic signed [wfwr_pkg::MULB_W-1:0] op_b;
	logic [W-1:0]        prod_low;
	logic [W-1:0]        fin;
	logic signed [WW:0]  neg_fz;
	logic signed [WW:0]  neg_tz;
	logic [W-1:0]        out_fy;
	logic [W-1:0]        out_ty;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	wfwr_sine u_sine (
		.clk     (clk),
		.angle   (angle_q),
		.sin_val (sin_val),
		.cos_val (cos_val)
	);

	wfwr_mac u_mac (
		.clk      (clk),
		.ctrl     (mac_ctrl),
		.op_a     (op_a),
		.op_b     (op_b),
		.vbias    (vbias_q),
		.prod_low (prod_low),
		.fin      (fin)
	);

	// Multiply schedule: each product lands in the cycle after it is issued, and each finished pair
	// is read from the accumulator behind it, the last pair once the output register is free.
	always_comb begin
		state_nxt        = state_q;
		mac_ctrl.acc_op  = wfwr_pkg::ACC_HOLD;
		mac_ctrl.bias_en = 1'b0;
		op_a             = w_q[0];
		op_b             = {sin_val[15], sin_val};
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_nxt = ST_RATE;
				end
			end
			ST_RATE: begin
				op_a      = $signed({1'b0, rate_q});
				op_b      = $signed({1'b0, dt_q});
				state_nxt = ST_ANGLE;
			end
			ST_ANGLE: state_nxt = ST_TRIG;
			ST_TRIG:  state_nxt = ST_FXS;
			ST_FXS: begin
				state_nxt = ST_FYC;
			end
			ST_FYC: begin
				op_a            = w_q[1];
				op_b            = {cos_val[15], cos_val};
				mac_ctrl.acc_op = wfwr_pkg::ACC_LOAD;
				state_nxt       = ST_FXC;
			end
			ST_FXC: begin
				op_b            = {cos_val[15], cos_val};
				mac_ctrl.acc_op = wfwr_pkg::ACC_SUB;
				state_nxt       = ST_FYS;
			end
			ST_FYS: begin
				op_a            = w_q[1];
				mac_ctrl.acc_op = wfwr_pkg::ACC_LOAD;
				state_nxt       = ST_TXS;
			end
			ST_TXS: begin
				op_a            = w_q[3];
				mac_ctrl.acc_op = wfwr_pkg::ACC_ADD;
				state_nxt       = ST_TYC;
			end
			ST_TYC: begin
				op_a             = w_q[4];
				op_b             = {cos_val[15], cos_val};
				mac_ctrl.acc_op  = wfwr_pkg::ACC_LOAD;
				mac_ctrl.bias_en = 1'b1;
				state_nxt        = ST_TXC;
			end
			ST_TXC: begin
				op_a            = w_q[3];
				op_b            = {cos_val[15], cos_val};
				mac_ctrl.acc_op = wfwr_pkg::ACC_SUB;
				state_nxt       = ST_TYS;
			end
			ST_TYS: begin
				op_a            = w_q[4];
				mac_ctrl.acc_op = wfwr_pkg::ACC_LOAD;
				state_nxt       = ST_LAST;
			end
			ST_LAST: begin
				mac_ctrl.acc_op = wfwr_pkg::ACC_ADD;
				state_nxt       = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Configuration registers and the wheel angle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			vbias_q <= '0;
			for (int i = 0; i < 6; i++) begin
				bias_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_ANGLE) begin
				angle_q <= angle_q + prod_low;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					wfwr_pkg::REG_START_ANGLE:   angle_q   <= cfg_data;
					wfwr_pkg::REG_VERTICAL_BIAS: vbias_q   <= cfg_data;
					wfwr_pkg::REG_BIAS_FORCE_X:  bias_q[0] <= cfg_data;
					wfwr_pkg::REG_BIAS_FORCE_Y:  bias_q[1] <= cfg_data;
					wfwr_pkg::REG_BIAS_FORCE_Z:  bias_q[2] <= cfg_data;
					wfwr_pkg::REG_BIAS_TORQUE_X: bias_q[3] <= cfg_data;
					wfwr_pkg::REG_BIAS_TORQUE_Y: bias_q[4] <= cfg_data;
					wfwr_pkg::REG_BIAS_TORQUE_Z: bias_q[5] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Offsets come off at capture, kept exact in 33 bits.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			for (int i = 0; i < 6; i++) begin
				w_q[i] <= $signed({s_axis_tdata[W*i+W-1], s_axis_tdata[W*i +: W]}) -
					$signed({bias_q[i][W-1], bias_q[i]});
			end
			rate_q <= s_axis_tdata[6*W +: W];
			dt_q   <= s_axis_tdata[7*W +: 16];
		end
		if (state_q == ST_FYS) begin
			res_fx_q <= fin;
		end
		if (state_q == ST_TYC) begin
			res_fz_q <= fin;
		end
		if (state_q == ST_TYS) begin
			res_tx_q <= fin;
		end
	end

	always_comb begin
		neg_fz = -$signed({w_q[2][WW-1], w_q[2]});
		neg_tz = -$signed({w_q[5][WW-1], w_q[5]});
		out_fy = wfwr_pkg::sat32({{(wfwr_pkg::FIN_W-WW-1){neg_fz[WW]}}, neg_fz});
		out_ty = wfwr_pkg::sat32({{(wfwr_pkg::FIN_W-WW-1){neg_tz[WW]}}, neg_tz});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_data_q <= {angle_q, fin, out_ty, res_tx_q, res_fz_q, out_fy, res_fx_q};
		end
	end

endmodule
